>>> sv/bis_pkg.sv
// Shared types and constants for the book imbalance slope unit.
// No dependencies.
package bis_pkg;

    localparam int IN_W             = 32;          // width of one quantity
    localparam int CFG_W            = 7;           // num_levels register width
    localparam int SLOPE_W          = 31;          // Q2.28 slope width
    localparam int QUO_W            = 31;          // divider quotient bits
    localparam int DIV_STEPS        = QUO_W;
    localparam int STEP_W           = $clog2(DIV_STEPS);
    localparam int FRAC_BITS        = 30;          // Q1.30 imbalance fraction
    localparam int NUM_LEVELS_RESET = 8;
    localparam int SLOPE_LIMIT      = 536870912;   // 2^29, slope clamp

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_MTI,
        S_MTT,
        S_ACC,
        S_M1,
        S_M2,
        S_M3,
        S_M4,
        S_PREP,
        S_FIN
    } t_state;

endpackage

>>> sv/book_imbalance_slope_unit.sv
// Least-squares slope of order-book imbalance against level, one level per transfer.
// Depends on bis_pkg (state type, field widths, divider constants).
//
// Each input transfer carries one book level (bid in tdata[31:0], ask in tdata[63:32]),
// nearest the touch first. The unit forms the Q1.30 imbalance (bid-ask)/(bid+ask),
// accumulates the regression sums, and after num_levels levels emits one Q2.28 slope
// (clamped to +/-2^29, 0 for a one-level window) and clears its sums. All arithmetic
// goes through one shared multiplier and one shared restoring divider stepped by a
// small sequencer; s_axis_tready is high only while the sequencer is idle. A level
// passes through accept, 31 divider steps and 3 accumulate steps, and skips the divider
// when both quantities are zero. The level that closes a window adds 4 multiplies,
// setup, 31 divider steps and output load, skipping the divider when the slope is zero
// or saturates, plus any wait for the previous slope to leave the output register.
// Throughput is set by the divider, which retires one quotient bit per cycle. The output
// register lets a new level be taken while a slope is still waiting downstream.
module book_imbalance_slope_unit #(
    parameter int MAX_LEVELS = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [bis_pkg::CFG_W-1:0] i_cfg_wr_data,   // num_levels
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [63:0]               s_axis_tdata,    // [31:0] bid_qty, [63:32] ask_qty
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [31:0]               m_axis_tdata     // [30:0] slope, [31] zero
);
    import bis_pkg::*;

    localparam int LW   = $clog2(MAX_LEVELS + 1);   // level index
    localparam int SLW  = 2 * LW;                   // sum of t
    localparam int SQW  = 3 * LW;                   // sum of t^2
    localparam int SIW  = LW + IN_W;                // sum of imbalance
    localparam int STIW = 2 * LW + IN_W;            // sum of t*imbalance
    localparam int PW   = SLW + 1 + STIW;           // multiplier product
    localparam int NUMW = PW + 1;                   // slope numerator
    localparam int DSW  = (PW + 1 > IN_W + 1) ? PW + 1 : IN_W + 1;   // divisor

    // control state
    t_state                   r_state, n_state;
    logic [CFG_W-1:0]         r_cfg, n_cfg;
    logic [LW-1:0]            r_count, n_count;
    logic [SLW-1:0]           r_sum_t, n_sum_t;
    logic [SQW-1:0]           r_sum_tt, n_sum_tt;
    logic signed [SIW-1:0]    r_sum_i, n_sum_i;
    logic signed [STIW-1:0]   r_sum_ti, n_sum_ti;
    logic                     r_out_valid, n_out_valid;

    // datapath
    logic                     r_neg, n_neg;
    logic                     r_sat, n_sat;
    logic                     r_slope_ph, n_slope_ph;
    logic [QUO_W-1:0]         r_quo, n_quo;
    logic [DSW-1:0]           r_rem, n_rem;
    logic [DSW-1:0]           r_dsr, n_dsr;
    logic [QUO_W-1:0]         r_dv, n_dv;
    logic [STEP_W-1:0]        r_step, n_step;
    logic signed [PW-1:0]     r_prod, n_prod;
    logic signed [PW-1:0]     r_acc, n_acc;
    logic signed [NUMW-1:0]   r_num, n_num;
    logic [SLOPE_W-1:0]       r_out_slope, n_out_slope;

    // combinational helpers
    logic [IN_W-1:0]          in_bid, in_ask, in_mag;
    logic [IN_W:0]            in_total;
    logic [LW-1:0]            t_cur, n_eff;
    logic [DSW:0]             rem_sh;
    logic [DSW+1:0]           diff;
    logic                     qbit;
    logic [DSW-1:0]           rem_nx;
    logic signed [31:0]       imb_val;
    logic [SLW-1:0]           mul_a;
    logic signed [STIW-1:0]   mul_b;
    logic signed [PW-1:0]     mul_out;
    logic signed [PW-1:0]     den;
    logic [DSW-1:0]           den_x4;
    logic [NUMW-1:0]          num_mag;
    logic [DSW-1:0]           num_hi;
    logic [QUO_W-1:0]         q_clamp;
    logic [SLOPE_W-1:0]       slope_val;

    assign in_bid   = s_axis_tdata[IN_W-1:0];
    assign in_ask   = s_axis_tdata[2*IN_W-1:IN_W];
    assign in_total = {1'b0, in_bid} + {1'b0, in_ask};
    assign in_mag   = (in_bid >= in_ask) ? in_bid - in_ask : in_ask - in_bid;

    assign t_cur = r_count + LW'(1);

    always_comb begin
        if (r_cfg == '0) begin
            n_eff = LW'(1);
        end else if (32'(r_cfg) > MAX_LEVELS) begin
            n_eff = LW'(MAX_LEVELS);
        end else begin
            n_eff = LW'(r_cfg);
        end
    end

    // shared restoring divider step: one quotient bit per cycle
    assign rem_sh = {r_rem, r_dv[QUO_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, r_dsr};
    assign qbit   = ~diff[DSW+1];
    assign rem_nx = qbit ? diff[DSW-1:0] : rem_sh[DSW-1:0];

    assign imb_val = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});

    // shared multiplier: unsigned a times signed b
    assign mul_out = $signed({1'b0, mul_a}) * mul_b;

    assign den     = r_acc - r_prod;
    assign den_x4  = DSW'({den[PW-2:0], 2'b00});
    assign num_mag = r_num[NUMW-1] ? unsigned'(-r_num) : unsigned'(r_num);
    assign num_hi  = DSW'(num_mag[NUMW-1:QUO_W]);

    assign q_clamp   = (r_sat || r_quo > QUO_W'(SLOPE_LIMIT)) ? QUO_W'(SLOPE_LIMIT) : r_quo;
    assign slope_val = r_neg ? SLOPE_W'(-q_clamp) : SLOPE_W'(q_clamp);

    always_comb begin
        n_state     = r_state;
        n_cfg       = r_cfg;
        n_count     = r_count;
        n_sum_t     = r_sum_t;
        n_sum_tt    = r_sum_tt;
        n_sum_i     = r_sum_i;
        n_sum_ti    = r_sum_ti;
        n_out_valid = r_out_valid;
        n_out_slope = r_out_slope;
        n_neg       = r_neg;
        n_sat       = r_sat;
        n_slope_ph  = r_slope_ph;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_dsr       = r_dsr;
        n_dv        = r_dv;
        n_step      = r_step;
        n_acc       = r_acc;
        n_num       = r_num;
        mul_a       = '0;
        mul_b       = '0;

        if (i_cfg_wr_en) begin
            n_cfg = i_cfg_wr_data;
        end
        if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_neg      = in_bid < in_ask;
                    n_sat      = 1'b0;
                    n_slope_ph = 1'b0;
                    n_quo      = '0;
                    // dividend is mag << 30; top bits seed the remainder
                    n_rem      = DSW'(in_mag[IN_W-1:1]);
                    n_dv       = {in_mag[0], {FRAC_BITS{1'b0}}};
                    n_dsr      = DSW'(in_total);
                    n_step     = STEP_W'(DIV_STEPS - 1);
                    n_state    = (in_total == '0) ? S_MTI : S_DIV;
                end
            end
            S_DIV: begin
                n_rem  = rem_nx;
                n_dv   = {r_dv[QUO_W-2:0], 1'b0};
                n_quo  = {r_quo[QUO_W-2:0], qbit};
                n_step = r_step - STEP_W'(1);
                if (r_step == '0) begin
                    n_state = r_slope_ph ? S_FIN : S_MTI;
                end
            end
            S_MTI: begin
                mul_a   = SLW'(t_cur);
                mul_b   = STIW'(imb_val);
                n_sum_t = r_sum_t + SLW'(t_cur);
                n_sum_i = r_sum_i + SIW'(imb_val);
                n_state = S_MTT;
            end
            S_MTT: begin
                mul_a    = SLW'(t_cur);
                mul_b    = STIW'($signed({1'b0, t_cur}));
                n_sum_ti = r_sum_ti + $signed(r_prod[STIW-1:0]);
                n_state  = S_ACC;
            end
            S_ACC: begin
                n_sum_tt = r_sum_tt + r_prod[SQW-1:0];
                n_count  = t_cur;
                n_state  = (t_cur >= n_eff) ? S_M1 : S_IDLE;
            end
            S_M1: begin
                mul_a   = SLW'(r_count);
                mul_b   = r_sum_ti;
                n_state = S_M2;
            end
            S_M2: begin
                mul_a   = r_sum_t;
                mul_b   = STIW'(r_sum_i);
                n_acc   = r_prod;
                n_state = S_M3;
            end
            S_M3: begin
                mul_a   = SLW'(r_count);
                mul_b   = STIW'($signed({1'b0, r_sum_tt}));
                n_num   = NUMW'(r_acc) - NUMW'(r_prod);
                n_state = S_M4;
            end
            S_M4: begin
                mul_a   = r_sum_t;
                mul_b   = STIW'($signed({1'b0, r_sum_t}));
                n_acc   = r_prod;
                n_state = S_PREP;
            end
            S_PREP: begin
                // divide |num| by 4*den; quotient past 31 bits saturates up front
                n_neg      = r_num[NUMW-1];
                n_slope_ph = 1'b1;
                n_quo      = '0;
                n_dsr      = den_x4;
                n_rem      = num_hi;
                n_dv       = num_mag[QUO_W-1:0];
                n_step     = STEP_W'(DIV_STEPS - 1);
                n_sat      = (den != '0) && (num_hi >= den_x4);
                n_state    = (den == '0 || n_sat) ? S_FIN : S_DIV;
            end
            S_FIN: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_slope = slope_val;
                    n_count     = '0;
                    n_sum_t     = '0;
                    n_sum_tt    = '0;
                    n_sum_i     = '0;
                    n_sum_ti    = '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg       <= CFG_W'(NUM_LEVELS_RESET);
            r_count     <= '0;
            r_sum_t     <= '0;
            r_sum_tt    <= '0;
            r_sum_i     <= '0;
            r_sum_ti    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cfg       <= n_cfg;
            r_count     <= n_count;
            r_sum_t     <= n_sum_t;
            r_sum_tt    <= n_sum_tt;
            r_sum_i     <= n_sum_i;
            r_sum_ti    <= n_sum_ti;
            r_out_valid <= n_out_valid;
        end
    end

    assign n_prod = mul_out;

    always_ff @(posedge i_clk) begin
        r_neg       <= n_neg;
        r_sat       <= n_sat;
        r_slope_ph  <= n_slope_ph;
        r_quo       <= n_quo;
        r_rem       <= n_rem;
        r_dsr       <= n_dsr;
        r_dv        <= n_dv;
        r_step      <= n_step;
        r_prod      <= n_prod;
        r_acc       <= n_acc;
        r_num       <= n_num;
        r_out_slope <= n_out_slope;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_slope};

    // a taken level leaves the sequencer busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while previous level still in work");

    // restoring divider invariant
    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_rem < r_dsr)
        else $error("divider remainder not below divisor");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= MAX_LEVELS)
        else $error("level count past maximum");

    a_slope_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[SLOPE_W-1:0]) <= SLOPE_LIMIT
                           && $signed(m_axis_tdata[SLOPE_W-1:0]) >= -SLOPE_LIMIT))
        else $error("slope outside clamp range");

    a_load_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state) == S_FIN)
        else $error("output loaded outside final step");

endmodule

>>> verif/book_imbalance_slope_checker.sv
// Checker for book_imbalance_slope_unit: tracks register writes and level transfers,
// predicts each window's Q2.28 slope and compares it with the output stream.
// Depends on bis_pkg (field widths, register reset value, slope clamp).
module book_imbalance_slope_checker #(
    parameter int MAX_LEVELS = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [bis_pkg::CFG_W-1:0] i_cfg_wr_data,   // num_levels
    input  logic                      s_axis_tvalid,
    input  logic                      s_axis_tready,
    input  logic [63:0]               s_axis_tdata,    // [31:0] bid_qty, [63:32] ask_qty
    input  logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    input  logic [31:0]               m_axis_tdata,    // [30:0] slope, [31] zero
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_slopes_seen
);

    logic [bis_pkg::CFG_W-1:0]   levels_cfg;
    int                          level_count;
    longint                      sum_t;
    longint                      sum_tt;
    longint                      sum_imb;
    longint                      sum_t_imb;
    logic [bis_pkg::SLOPE_W-1:0] slope_q[$];
    int                          fails = 0;
    int                          seen = 0;

    // Q1.30 (bid-ask)/(bid+ask), truncated toward zero
    function automatic longint level_imbalance(input logic [31:0] bid, input logic [31:0] ask);
        logic [63:0] total;
        logic [63:0] mag;
        logic [63:0] q;
        total = 64'(bid) + 64'(ask);
        if (total == 0)
            return 0;
        mag = (bid >= ask) ? 64'(bid) - 64'(ask) : 64'(ask) - 64'(bid);
        q = (mag << bis_pkg::FRAC_BITS) / total;
        return (bid >= ask) ? longint'(q) : -longint'(q);
    endfunction

    // least-squares slope in Q2.28: num / (4*den), clamped to +/-2^29
    function automatic logic [bis_pkg::SLOPE_W-1:0] window_slope(
        input longint n, input longint st, input longint stt,
        input longint si, input longint sti
    );
        longint      num;
        longint      den;
        logic [63:0] mag;
        logic [63:0] q;
        longint      r;
        num = n * sti - st * si;
        den = n * stt - st * st;
        if (den <= 0)
            return '0;
        mag = (num < 0) ? 64'(-num) : 64'(num);
        q = mag / (64'(den) * 4);
        if (q > 64'(bis_pkg::SLOPE_LIMIT))
            q = 64'(bis_pkg::SLOPE_LIMIT);
        r = longint'(q);
        if (num < 0)
            r = -r;
        return r[bis_pkg::SLOPE_W-1:0];
    endfunction

    always @(posedge i_clk) begin : monitor
        logic [bis_pkg::SLOPE_W-1:0] want;
        longint                      imb;
        longint                      t;
        int                          n_eff;
        if (!i_rst_n) begin
            levels_cfg  = bis_pkg::NUM_LEVELS_RESET;
            level_count = 0;
            sum_t       = 0;
            sum_tt      = 0;
            sum_imb     = 0;
            sum_t_imb   = 0;
            slope_q.delete();
        end else begin
            // output first, so a new expectation never pairs with an earlier stray result
            if (m_axis_tvalid && m_axis_tready) begin
                seen++;
                if (slope_q.size() == 0) begin
                    $error("slope transfer %0d with none expected", $signed(m_axis_tdata[30:0]));
                    fails++;
                end else begin
                    want = slope_q.pop_front();
                    if (m_axis_tdata[30:0] !== want) begin
                        $error("slope: expected %0d, actual %0d",
                               $signed(want), $signed(m_axis_tdata[30:0]));
                        fails++;
                    end
                    if (m_axis_tdata[31] !== 1'b0) begin
                        $error("pad: expected 0, actual %b", m_axis_tdata[31]);
                        fails++;
                    end
                end
            end
            if (i_cfg_wr_en)
                levels_cfg = i_cfg_wr_data;
            if (s_axis_tvalid && s_axis_tready) begin
                n_eff = (levels_cfg == 0) ? 1 : int'(levels_cfg);
                if (n_eff > MAX_LEVELS)
                    n_eff = MAX_LEVELS;
                t = level_count + 1;
                imb = level_imbalance(s_axis_tdata[31:0], s_axis_tdata[63:32]);
                sum_t     += t;
                sum_tt    += t * t;
                sum_imb   += imb;
                sum_t_imb += t * imb;
                level_count++;
                // a lowered register closes the window on the next level
                if (level_count >= n_eff) begin
                    slope_q.push_back(window_slope(level_count, sum_t, sum_tt,
                                                   sum_imb, sum_t_imb));
                    level_count = 0;
                    sum_t       = 0;
                    sum_tt      = 0;
                    sum_imb     = 0;
                    sum_t_imb   = 0;
                end
            end
        end
        o_fail_count  <= fails;
        o_pending     <= slope_q.size();
        o_slopes_seen <= seen;
    end

endmodule

>>> verif/tb.sv
// Testbench top for book_imbalance_slope_unit: drives register writes and book levels,
// shapes output back-pressure, and reports the verdict.
// Depends on bis_pkg, book_imbalance_slope_unit and book_imbalance_slope_checker.
module tb;

    localparam int MAX_LEVELS    = 64;
    localparam int LIMIT_CYCLES  = 1_000_000;
    localparam int SETTLE_CYCLES = 120;
    localparam int HOLD_CYCLES   = 600;
    localparam int TARGET_LEVELS = 1100;
    localparam logic [31:0] QTY_MAX = 32'hFFFF_FFFF;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_wr_en = 1'b0;
    logic [bis_pkg::CFG_W-1:0] i_cfg_wr_data = '0;   // num_levels
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [63:0]               s_axis_tdata = '0;    // [31:0] bid_qty, [63:32] ask_qty
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [31:0]               m_axis_tdata;         // [30:0] slope, [31] zero

    int          fail_count;
    int          pending;
    int          slopes_seen;
    int          levels_sent = 0;
    int          settings_used = 0;
    int          burst_left = 0;
    int          hold_reqs = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          rx_mode = 0;
    int unsigned cycles = 0;

    book_imbalance_slope_unit #(.MAX_LEVELS(MAX_LEVELS)) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    book_imbalance_slope_checker #(.MAX_LEVELS(MAX_LEVELS)) slope_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_slopes_seen (slopes_seen)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d slopes still expected", cycles, pending);
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: long hold on request, otherwise one of four stall patterns, rechosen at random
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_reqs) begin
            hold_seen <= hold_reqs;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            if (cycles % 256 == 0)
                rx_mode <= $urandom_range(0, 3);
            case (rx_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= 1'($urandom_range(0, 1));
                2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= ((cycles % 8) < 5);
            endcase
        end
    end

    // one level transfer; bursts of random length, with idle gaps between them
    task automatic send_level(input logic [31:0] bid, input logic [31:0] ask);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? $urandom_range(4, 40) : $urandom_range(1, 3);
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ask, bid};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        levels_sent++;
        burst_left--;
        if (burst_left == 0)
            s_axis_tvalid <= 1'b0;
    endtask

    // wait for every expected slope, then for any level still in the divider
    task automatic settle();
        if (burst_left != 0) begin
            s_axis_tvalid <= 1'b0;
            burst_left = 0;
        end
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_levels(input int value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= bis_pkg::CFG_W'(value);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [31:0] random_qty();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'($urandom_range(0, 1000));
            2: return QTY_MAX - 32'($urandom_range(0, 3));
            3: return {1'b1, 31'($urandom())};
            4: return 32'($urandom_range(1, 1 << 20));
            default: return 32'($urandom()) >> $urandom_range(0, 31);
        endcase
    endfunction

    // a book snapshot: levels past the depth are sent empty, with some noise mixed in
    task automatic send_book(input int count, input int depth);
        logic [31:0] bid;
        logic [31:0] ask;
        for (int t = 1; t <= count; t++) begin
            if ($urandom_range(0, 9) == 0) begin
                bid = $urandom_range(0, 1) ? random_qty() : '0;
                ask = $urandom_range(0, 1) ? random_qty() : '0;
            end else if (t > depth) begin
                bid = '0;
                ask = '0;
            end else begin
                case ($urandom_range(0, 5))
                    0: begin bid = random_qty(); ask = '0; end
                    1: begin bid = '0; ask = random_qty(); end
                    2: begin bid = random_qty(); ask = bid; end
                    default: begin bid = random_qty(); ask = random_qty(); end
                endcase
            end
            send_level(bid, ask);
        end
    endtask

    initial begin
        int setting;
        int n_eff;
        int windows;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset window of 8: empty level, one-sided books, full-scale and near-equal sizes
        send_level('0, '0);
        send_level(QTY_MAX, '0);
        send_level('0, QTY_MAX);
        send_level(QTY_MAX, QTY_MAX);
        send_level(32'd1, '0);
        send_level('0, 32'd1);
        send_level(QTY_MAX, QTY_MAX - 1);
        send_level(32'd1, 32'd1);
        settle();
        // two-level windows that reach the slope clamp in both directions
        set_levels(2);
        send_level('0, QTY_MAX);
        send_level(QTY_MAX, '0);
        send_level(QTY_MAX, '0);
        send_level('0, QTY_MAX);
        settle();
        // one-level windows have a zero denominator
        set_levels(1);
        send_level(QTY_MAX, '0);
        send_level('0, '0);
        settle();
        set_levels(0);
        send_level('0, QTY_MAX);
        settle();
        // register lowered below the level count mid-window
        set_levels(4);
        send_level(32'd100, 32'd300);
        send_level(32'd300, 32'd100);
        send_level(QTY_MAX, 32'd7);
        settle();
        set_levels(2);
        send_level(32'd5, QTY_MAX);
        settle();

        // long receiver hold with one slope per level, sender kept busy
        set_levels(1);
        hold_reqs <= hold_reqs + 1;
        burst_left = 40;
        send_book(40, 40);
        settle();
        set_levels(MAX_LEVELS);
        send_book(MAX_LEVELS, $urandom_range(1, MAX_LEVELS));
        settle();
        set_levels(127);
        send_book(MAX_LEVELS, MAX_LEVELS);

        while (levels_sent < TARGET_LEVELS) begin
            settle();
            case ($urandom_range(0, 19))
                0: setting = 0;
                1: setting = MAX_LEVELS;
                2: setting = $urandom_range(MAX_LEVELS + 1, 127);
                3, 4, 5: setting = $urandom_range(9, 20);
                default: setting = $urandom_range(1, 8);
            endcase
            set_levels(setting);
            n_eff = (setting == 0) ? 1 : (setting > MAX_LEVELS) ? MAX_LEVELS : setting;
            windows = (n_eff > 16) ? 1 : $urandom_range(1, 4);
            repeat (windows) send_book(n_eff, $urandom_range(0, n_eff));
            // sometimes leave a window open across the next register write
            if ($urandom_range(0, 3) == 0)
                send_book($urandom_range(0, n_eff - 1), n_eff);
        end
        settle();

        $display("Run: %0d levels under %0d num_levels writes, %0d slopes compared",
                 levels_sent, settings_used, slopes_seen);
        $display("Covered one-level, clamped, over-range and lowered-register windows");
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
